// File: src/spc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skin pixel classifier package
// Widths, chroma coefficients, rule constants and register indexes.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int PIX_W   = 8;
    localparam int SUM_W   = 10;
    localparam int CHR_W   = 26;
    localparam int RULE_W  = 22;
    localparam int WIDE_W  = 36;
    localparam int SQ_W    = 20;
    localparam int PROD_W  = 16;
    localparam int CUBE_W  = 30;
    localparam int BRR_W   = 24;
    localparam int QT_W    = 25;
    localparam int E_W     = 21;

    typedef logic [1:0] t_cfg_index;

    localparam t_cfg_index CFG_CB_LOW  = 2'd0;
    localparam t_cfg_index CFG_CB_HIGH = 2'd1;
    localparam t_cfg_index CFG_CR_LOW  = 2'd2;
    localparam t_cfg_index CFG_CR_HIGH = 2'd3;

    localparam logic [PIX_W-1:0] CB_LOW_RST  = 8'd77;
    localparam logic [PIX_W-1:0] CB_HIGH_RST = 8'd127;
    localparam logic [PIX_W-1:0] CR_LOW_RST  = 8'd133;
    localparam logic [PIX_W-1:0] CR_HIGH_RST = 8'd173;

    // Q16 chroma coefficients.
    localparam logic signed [CHR_W-1:0] CB_R   = 26'sd11056;
    localparam logic signed [CHR_W-1:0] CB_G   = 26'sd21706;
    localparam logic signed [CHR_W-1:0] CB_B   = 26'sd32768;
    localparam logic signed [CHR_W-1:0] CR_R   = 26'sd32768;
    localparam logic signed [CHR_W-1:0] CR_G   = 26'sd27414;
    localparam logic signed [CHR_W-1:0] CR_B   = 26'sd5348;
    localparam logic signed [CHR_W-1:0] CH_OFS = 26'sd8388608;
    localparam logic signed [CHR_W-1:0] CH_MAX = 26'sd16711680;

    // RGB rule constants.
    localparam logic [RULE_W-1:0] K_1000  = 22'd1000;
    localparam logic [RULE_W-1:0] K_1249  = 22'd1249;
    localparam logic [RULE_W-1:0] K_2076  = 22'd2076;
    localparam logic [RULE_W-1:0] K_10000 = 22'd10000;
    localparam logic [RULE_W-1:0] K_3043  = 22'd3043;
    localparam logic [RULE_W-1:0] K_372   = 22'd372;

    // Chroma rule ratio constants.
    localparam logic [WIDE_W-1:0] T1_L  = 36'd3000;
    localparam logic [WIDE_W-1:0] T1_R  = 36'd110;
    localparam logic [WIDE_W-1:0] T2_G  = 36'd5000;
    localparam logic [WIDE_W-1:0] T3_S  = 36'd10000;
    localparam logic [WIDE_W-1:0] T3_E  = 36'd27775;

endpackage

// File: src/skin_pixel_classifier_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Skin pixel classifier
// Flags an RGB pixel as skin using an RGB rule or a ratio and chroma rule.
// An accepted input beat passes the stage 1, 2, 3 and 4 registers in order to a valid result beat.
// Throughput is one pixel per cycle when not stalled, through a four-stage multiplier pipeline.
// A stalled result holds the whole pipeline; nothing is dropped or repeated.
// Reset clears all stage valids and loads the default chroma windows.
// ----------------------------------------------------------------------------
module skin_pixel_classifier_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [spc_pkg::PIX_W-1:0] i_red,
    input  logic [spc_pkg::PIX_W-1:0] i_green,
    input  logic [spc_pkg::PIX_W-1:0] i_blue,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic                      o_is_skin,
    input  logic                      i_cfg_we,
    input  spc_pkg::t_cfg_index       i_cfg_index,
    input  logic [spc_pkg::PIX_W-1:0] i_cfg_data
);

    logic [spc_pkg::PIX_W-1:0] r_cb_low, r_cb_high, r_cr_low, r_cr_high;

    logic w_adv;

    // Stage 1 registers.
    logic                              r_v1;
    logic [spc_pkg::PIX_W-1:0]         r_s1_r, r_s1_g, r_s1_b;
    logic [spc_pkg::SUM_W-1:0]         r_s1_s;
    logic                              r_s1_rgb;
    logic signed [spc_pkg::CHR_W-1:0]  r_s1_cb, r_s1_cr;
    logic [spc_pkg::SUM_W-1:0]         n_s1_s;
    logic                              n_s1_rgb;
    logic signed [spc_pkg::CHR_W-1:0]  n_s1_cb, n_s1_cr;

    // Stage 2 registers.
    logic                              r_v2;
    logic [spc_pkg::PIX_W-1:0]         r_s2_r, r_s2_g, r_s2_b;
    logic [spc_pkg::SUM_W-1:0]         r_s2_s;
    logic                              r_s2_rgb, r_s2_win;
    logic [spc_pkg::PROD_W-1:0]        r_s2_rr, r_s2_rb, r_s2_gg;
    logic [spc_pkg::SQ_W-1:0]          r_s2_ss, r_s2_rs;
    logic                              n_s2_win;

    // Stage 3 registers.
    logic                              r_v3;
    logic [spc_pkg::PIX_W-1:0]         r_s3_g;
    logic                              r_s3_s_nz;
    logic                              r_s3_rgb, r_s3_win;
    logic [spc_pkg::BRR_W-1:0]         r_s3_brr;
    logic [spc_pkg::CUBE_W-1:0]        r_s3_sss;
    logic [spc_pkg::QT_W-1:0]          r_s3_q;
    logic signed [spc_pkg::E_W-1:0]    r_s3_e;
    logic [spc_pkg::SQ_W-1:0]          r_s3_ss;

    // Stage 4 registers.
    logic                              r_v4;
    logic                              r_s4_skin;
    logic                              n_s4_skin;

    assign w_adv     = !(r_v4 && i_stall);
    assign o_stall   = r_v4 && i_stall;
    assign o_valid   = r_v4;
    assign o_is_skin = r_s4_skin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cb_low  <= spc_pkg::CB_LOW_RST;
            r_cb_high <= spc_pkg::CB_HIGH_RST;
            r_cr_low  <= spc_pkg::CR_LOW_RST;
            r_cr_high <= spc_pkg::CR_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                spc_pkg::CFG_CB_LOW:  r_cb_low  <= i_cfg_data;
                spc_pkg::CFG_CB_HIGH: r_cb_high <= i_cfg_data;
                spc_pkg::CFG_CR_LOW:  r_cr_low  <= i_cfg_data;
                spc_pkg::CFG_CR_HIGH: r_cr_high <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: sum, the complete RGB rule and the raw Q16 chroma values.
    always_comb begin
        logic [spc_pkg::RULE_W-1:0] r22, g22, b22, s22;
        logic [spc_pkg::PIX_W-1:0]  mx, mn;
        logic signed [spc_pkg::CHR_W-1:0] sr, sg, sb;
        r22 = spc_pkg::RULE_W'(i_red);
        g22 = spc_pkg::RULE_W'(i_green);
        b22 = spc_pkg::RULE_W'(i_blue);
        n_s1_s = spc_pkg::SUM_W'(i_red) + spc_pkg::SUM_W'(i_green)
               + spc_pkg::SUM_W'(i_blue);
        s22 = spc_pkg::RULE_W'(n_s1_s);
        mx = (i_red > i_green) ? i_red : i_green;
        mn = (i_red < i_green) ? i_red : i_green;
        if (i_blue > mx) begin
            mx = i_blue;
        end
        if (i_blue < mn) begin
            mn = i_blue;
        end
        n_s1_rgb = (i_red > 8'd95) && (i_green > 8'd40) && (i_blue > 8'd20)
                && ((mx - mn) > 8'd15)
                && (i_red > i_green) && ((i_red - i_green) > 8'd15)
                && (i_red > i_blue)
                && (spc_pkg::K_1000 * b22 < spc_pkg::K_1249 * g22)
                && ({b22[spc_pkg::RULE_W-2:0], 1'b0} > g22)
                && (spc_pkg::K_1000 * s22 > spc_pkg::K_2076 * r22)
                && (spc_pkg::K_10000 * b22 < spc_pkg::K_3043 * s22)
                && (spc_pkg::K_1000 * g22 < spc_pkg::K_372 * s22);
        sr = $signed(spc_pkg::CHR_W'(i_red));
        sg = $signed(spc_pkg::CHR_W'(i_green));
        sb = $signed(spc_pkg::CHR_W'(i_blue));
        n_s1_cb = spc_pkg::CH_OFS + spc_pkg::CB_B * sb
                - spc_pkg::CB_R * sr - spc_pkg::CB_G * sg;
        n_s1_cr = spc_pkg::CH_OFS + spc_pkg::CR_R * sr
                - spc_pkg::CR_G * sg - spc_pkg::CR_B * sb;
    end

    // Stage 2: clamped chroma window test.
    always_comb begin
        logic signed [spc_pkg::CHR_W-1:0] cb, cr;
        cb = r_s1_cb;
        cr = r_s1_cr;
        if (cb < 0) begin
            cb = '0;
        end else if (cb > spc_pkg::CH_MAX) begin
            cb = spc_pkg::CH_MAX;
        end
        if (cr < 0) begin
            cr = '0;
        end else if (cr > spc_pkg::CH_MAX) begin
            cr = spc_pkg::CH_MAX;
        end
        n_s2_win = (cb >= $signed({2'b00, r_cb_low, 16'h0000}))
                && (cb <= $signed({2'b00, r_cb_high, 16'h0000}))
                && (cr >= $signed({2'b00, r_cr_low, 16'h0000}))
                && (cr <= $signed({2'b00, r_cr_high, 16'h0000}));
    end

    // Stage 4: final ratio compares and the result.
    always_comb begin
        logic t1, t2, t3;
        logic [spc_pkg::WIDE_W-1:0] e36;
        e36 = spc_pkg::WIDE_W'(r_s3_e[spc_pkg::E_W-2:0]);
        t1 = (spc_pkg::T1_L * spc_pkg::WIDE_W'(r_s3_brr))
           > (spc_pkg::T1_R * spc_pkg::WIDE_W'(r_s3_sss));
        t2 = spc_pkg::WIDE_W'(r_s3_q) > spc_pkg::T2_G * spc_pkg::WIDE_W'(r_s3_g);
        t3 = r_s3_s_nz && (r_s3_e[spc_pkg::E_W-1]
           || (spc_pkg::T3_S * spc_pkg::WIDE_W'(r_s3_ss) < spc_pkg::T3_E * e36));
        n_s4_skin = r_s3_rgb || (t1 && t2 && t3 && r_s3_win);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_r   <= i_red;
            r_s1_g   <= i_green;
            r_s1_b   <= i_blue;
            r_s1_s   <= n_s1_s;
            r_s1_rgb <= n_s1_rgb;
            r_s1_cb  <= n_s1_cb;
            r_s1_cr  <= n_s1_cr;

            r_s2_r   <= r_s1_r;
            r_s2_g   <= r_s1_g;
            r_s2_b   <= r_s1_b;
            r_s2_s   <= r_s1_s;
            r_s2_rgb <= r_s1_rgb;
            r_s2_win <= n_s2_win;
            r_s2_rr  <= spc_pkg::PROD_W'(r_s1_r) * spc_pkg::PROD_W'(r_s1_r);
            r_s2_rb  <= spc_pkg::PROD_W'(r_s1_r) * spc_pkg::PROD_W'(r_s1_b);
            r_s2_gg  <= spc_pkg::PROD_W'(r_s1_g) * spc_pkg::PROD_W'(r_s1_g);
            r_s2_ss  <= spc_pkg::SQ_W'(r_s1_s) * spc_pkg::SQ_W'(r_s1_s);
            r_s2_rs  <= spc_pkg::SQ_W'(r_s1_r) * spc_pkg::SQ_W'(r_s1_s);

            r_s3_g    <= r_s2_g;
            r_s3_s_nz <= (r_s2_s != '0);
            r_s3_rgb  <= r_s2_rgb;
            r_s3_win  <= r_s2_win;
            r_s3_ss   <= r_s2_ss;
            r_s3_brr  <= spc_pkg::BRR_W'(r_s2_b) * spc_pkg::BRR_W'(r_s2_rr);
            r_s3_sss  <= spc_pkg::CUBE_W'(r_s2_s) * spc_pkg::CUBE_W'(r_s2_ss);
            r_s3_q    <= (spc_pkg::QT_W'(r_s2_rb) + spc_pkg::QT_W'(r_s2_gg))
                       * spc_pkg::QT_W'(r_s2_b);
            r_s3_e    <= $signed(spc_pkg::E_W'(r_s2_rs) + spc_pkg::E_W'(r_s2_rs)
                       + spc_pkg::E_W'(r_s2_rs) + spc_pkg::E_W'(r_s2_r)
                       - spc_pkg::E_W'(r_s2_g));

            r_s4_skin <= n_s4_skin;
        end
    end

endmodule
